// ===== rtl/ohlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlt_pkg
// Opcode and status codes shared by the open-handle lock table and its checker.
// ----------------------------------------------------------------------------
package ohlt_pkg;

  // command opcodes (code 3 has no meaning and gives an all-zero result)
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DENIED    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned REF_W = 16;
  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

endpackage : ohlt_pkg
`default_nettype wire

// ===== rtl/open_handle_lock_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// open_handle_lock_table_unit
// Reference-counted reader/writer lock table: a handle table and a file table
// kept in two synchronous memories, searched one entry per cycle.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | transfer when
//  ----------+------------------------------------------------+----------------
//  command   | start, busy, opcode_i, handle_key_i,           | start && !busy
//            | file_key_i, want_exclusive_i                   |
//  result    | result_valid_o, status_o,                      | result_valid_o
//            | release_underlying_o, ref_count_o              |
//
// A command walks the handle memory one entry per cycle and stops on a hit
// or at its last entry; an open of a new handle then walks the file memory
// the same way. A hit is acted on in S_HACT and a release in S_FREL. The
// result strobe follows the last busy cycle; the unused opcode answers in
// the cycle after its transfer without raising busy.
// Reset empties both tables at once through their valid flip-flops.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module open_handle_lock_table_unit
  import ohlt_pkg::*;
#(
  parameter int unsigned HANDLE_SLOTS = 16,
  parameter int unsigned FILE_SLOTS   = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [KEY_W-1:0] handle_key_i,
  input  wire logic [KEY_W-1:0] file_key_i,
  input  wire logic             want_exclusive_i,
  output logic                  result_valid_o,
  output logic [2:0]            status_o,
  output logic                  release_underlying_o,
  output logic [REF_W-1:0]      ref_count_o
);

  localparam int unsigned HIW  = $clog2(HANDLE_SLOTS);
  localparam int unsigned FIW  = $clog2(FILE_SLOTS);
  localparam int unsigned CNTW = $clog2(HANDLE_SLOTS + 1);
  localparam logic [HIW-1:0] H_LAST = HIW'(HANDLE_SLOTS - 1);
  localparam logic [FIW-1:0] F_LAST = FIW'(FILE_SLOTS - 1);

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [FIW-1:0]   fslot;
    logic [REF_W-1:0] refs;
  } hent_t;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [CNTW-1:0]  cnt;
    logic             excl;
  } fent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HSCAN,
    S_HACT,
    S_FSCAN,
    S_FREL
  } state_e;

  // control state
  state_e                  state_q, state_d;
  logic                    busy_q, busy_d;
  logic                    rvalid_q, rvalid_d;
  logic [2:0]              status_q, status_d;
  logic                    release_q, release_d;
  logic [REF_W-1:0]        refs_q, refs_d;
  logic [HIW-1:0]          hidx_q, hidx_d;
  logic [FIW-1:0]          fidx_q, fidx_d;
  logic [HANDLE_SLOTS-1:0] hvalid_q, hvalid_d;
  logic [FILE_SLOTS-1:0]   fvalid_q, fvalid_d;
  logic                    hfree_ok_q, hfree_ok_d;
  logic                    ffree_ok_q, ffree_ok_d;

  // command and search payload
  logic [1:0]       op_q, op_d;
  logic [KEY_W-1:0] hkey_q, hkey_d;
  logic [KEY_W-1:0] fkey_q, fkey_d;
  logic             excl_q, excl_d;
  logic [HIW-1:0]   hslot_q, hslot_d;
  hent_t            hent_q, hent_d;
  logic [HIW-1:0]   hfree_q, hfree_d;
  logic [FIW-1:0]   ffree_q, ffree_d;

  // memories and their ports
  hent_t          hmem [HANDLE_SLOTS];
  fent_t          fmem [FILE_SLOTS];
  hent_t          hrd_q;
  fent_t          frd_q;
  logic           hwe;
  logic [HIW-1:0] hwaddr;
  hent_t          hwdata;
  logic           fwe;
  logic [FIW-1:0] fwaddr;
  fent_t          fwdata;

  // admission of a new handle
  logic            admit;
  logic [FIW-1:0]  adm_fslot;
  logic [CNTW-1:0] adm_cnt;

  // search helpers
  logic             accept;
  logic             h_match, h_last, h_free_ok;
  logic [HIW-1:0]   h_free_slot;
  logic             f_match, f_last, f_free_ok;
  logic [FIW-1:0]   f_free_slot;
  logic [REF_W-1:0] refs_inc, refs_dec;
  logic [CNTW-1:0]  cnt_dec;
  logic             f_deny;

  assign accept = start && !busy_q;

  assign h_match     = hvalid_q[hidx_q] && (hrd_q.id == hkey_q);
  assign h_last      = (hidx_q == H_LAST);
  assign h_free_ok   = hfree_ok_q || !hvalid_q[hidx_q];
  assign h_free_slot = hfree_ok_q ? hfree_q : hidx_q;

  assign f_match     = fvalid_q[fidx_q] && (frd_q.id == fkey_q);
  assign f_last      = (fidx_q == F_LAST);
  assign f_free_ok   = ffree_ok_q || !fvalid_q[fidx_q];
  assign f_free_slot = ffree_ok_q ? ffree_q : fidx_q;
  assign f_deny      = frd_q.excl || ((frd_q.cnt != '0) && excl_q);

  assign refs_inc = hent_q.refs + REF_W'(1);
  assign refs_dec = (hent_q.refs == '0) ? '0 : hent_q.refs - REF_W'(1);
  assign cnt_dec  = (frd_q.cnt == '0) ? '0 : frd_q.cnt - CNTW'(1);

  // next state and memory write control
  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    rvalid_d   = 1'b0;
    status_d   = status_q;
    release_d  = release_q;
    refs_d     = refs_q;
    hidx_d     = hidx_q;
    fidx_d     = fidx_q;
    hvalid_d   = hvalid_q;
    fvalid_d   = fvalid_q;
    hfree_ok_d = hfree_ok_q;
    ffree_ok_d = ffree_ok_q;
    op_d       = op_q;
    hkey_d     = hkey_q;
    fkey_d     = fkey_q;
    excl_d     = excl_q;
    hslot_d    = hslot_q;
    hent_d     = hent_q;
    hfree_d    = hfree_q;
    ffree_d    = ffree_q;
    hwe        = 1'b0;
    hwaddr     = hslot_q;
    hwdata     = hent_q;
    fwe        = 1'b0;
    fwaddr     = fidx_q;
    fwdata     = frd_q;
    admit      = 1'b0;
    adm_fslot  = fidx_q;
    adm_cnt    = CNTW'(1);

    case (state_q)
      S_IDLE: begin
        hidx_d = '0;
        if (accept) begin
          op_d       = opcode_i;
          hkey_d     = handle_key_i;
          fkey_d     = file_key_i;
          excl_d     = want_exclusive_i;
          hfree_ok_d = 1'b0;
          if (opcode_i inside {OP_OPEN, OP_CLOSE, OP_QUERY}) begin
            state_d = S_HSCAN;
            busy_d  = 1'b1;
          end else begin
            // meaningless opcode: all-zero answer, no state change
            rvalid_d  = 1'b1;
            status_d  = ST_OK;
            release_d = 1'b0;
            refs_d    = '0;
          end
        end
      end

      // walk the handle memory, note the lowest free slot on the way
      S_HSCAN: begin
        hfree_ok_d = h_free_ok;
        hfree_d    = h_free_slot;
        if (h_match) begin
          hslot_d = hidx_q;
          hent_d  = hrd_q;
          state_d = S_HACT;
        end else if (h_last) begin
          if (op_q == OP_OPEN) begin
            fidx_d     = '0;
            ffree_ok_d = 1'b0;
            state_d    = S_FSCAN;
          end else begin
            state_d   = S_IDLE;
            busy_d    = 1'b0;
            rvalid_d  = 1'b1;
            status_d  = ST_NOT_FOUND;
            release_d = 1'b0;
            refs_d    = '0;
          end
        end else begin
          hidx_d = hidx_q + HIW'(1);
        end
      end

      // found: open raises a non-max refcount, close lowers it, query only reports it
      S_HACT: begin
        state_d   = S_IDLE;
        busy_d    = 1'b0;
        rvalid_d  = 1'b1;
        status_d  = ST_OK;
        release_d = 1'b0;
        refs_d    = hent_q.refs;
        case (op_q)
          OP_OPEN: begin
            if (hent_q.refs == REF_MAX) begin
              status_d = ST_OVERFLOW;
            end else begin
              hwe         = 1'b1;
              hwdata.refs = refs_inc;
              refs_d      = refs_inc;
            end
          end
          OP_CLOSE: begin
            if (refs_dec != '0) begin
              hwe         = 1'b1;
              hwdata.refs = refs_dec;
              refs_d      = refs_dec;
            end else begin
              // last reference gone: fetch the file entry first
              fidx_d   = hent_q.fslot;
              state_d  = S_FREL;
              busy_d   = 1'b1;
              rvalid_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // free the handle and drop one count from its file
      S_FREL: begin
        hvalid_d[hslot_q] = 1'b0;
        if (fvalid_q[fidx_q]) begin
          fwe        = 1'b1;
          fwdata.cnt = cnt_dec;
          if (cnt_dec == '0) begin
            fvalid_d[fidx_q] = 1'b0;
          end
        end
        state_d   = S_IDLE;
        busy_d    = 1'b0;
        rvalid_d  = 1'b1;
        status_d  = ST_OK;
        release_d = 1'b1;
        refs_d    = '0;
      end

      // walk the file memory for a new handle
      S_FSCAN: begin
        ffree_ok_d = f_free_ok;
        ffree_d    = f_free_slot;
        if (f_match || f_last) begin
          state_d   = S_IDLE;
          busy_d    = 1'b0;
          rvalid_d  = 1'b1;
          release_d = 1'b0;
          refs_d    = '0;
          status_d  = ST_FULL;
          if (f_match) begin
            if (f_deny) begin
              status_d = ST_DENIED;
            end else if (hfree_ok_q) begin
              admit     = 1'b1;
              adm_fslot = fidx_q;
              adm_cnt   = frd_q.cnt + CNTW'(1);
            end
          end else if (hfree_ok_q && f_free_ok) begin
            admit     = 1'b1;
            adm_fslot = f_free_slot;
            adm_cnt   = CNTW'(1);
          end
        end else begin
          fidx_d = fidx_q + FIW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase

    // store a new handle and count it against its file
    if (admit) begin
      fwe                = 1'b1;
      fwaddr             = adm_fslot;
      fwdata.id          = fkey_q;
      fwdata.cnt         = adm_cnt;
      fwdata.excl        = excl_q;
      fvalid_d[adm_fslot] = 1'b1;
      hwe                = 1'b1;
      hwaddr             = hfree_q;
      hwdata.id          = hkey_q;
      hwdata.fslot       = adm_fslot;
      hwdata.refs        = REF_W'(1);
      hvalid_d[hfree_q]  = 1'b1;
      status_d           = ST_OK;
      refs_d             = REF_W'(1);
    end
  end

  // state machine and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      busy_q     <= 1'b0;
      rvalid_q   <= 1'b0;
      status_q   <= ST_OK;
      release_q  <= 1'b0;
      refs_q     <= '0;
      hidx_q     <= '0;
      fidx_q     <= '0;
      hvalid_q   <= '0;
      fvalid_q   <= '0;
      hfree_ok_q <= 1'b0;
      ffree_ok_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      busy_q     <= busy_d;
      rvalid_q   <= rvalid_d;
      status_q   <= status_d;
      release_q  <= release_d;
      refs_q     <= refs_d;
      hidx_q     <= hidx_d;
      fidx_q     <= fidx_d;
      hvalid_q   <= hvalid_d;
      fvalid_q   <= fvalid_d;
      hfree_ok_q <= hfree_ok_d;
      ffree_ok_q <= ffree_ok_d;
    end
  end

  // command and search payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    hkey_q  <= hkey_d;
    fkey_q  <= fkey_d;
    excl_q  <= excl_d;
    hslot_q <= hslot_d;
    hent_q  <= hent_d;
    hfree_q <= hfree_d;
    ffree_q <= ffree_d;
  end

  // handle memory, registered read at the next scan index
  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hmem[hwaddr] <= hwdata;
    end
    hrd_q <= hmem[hidx_d];
  end

  // file memory, registered read at the next scan index
  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fmem[fwaddr] <= fwdata;
    end
    frd_q <= fmem[fidx_d];
  end

  assign busy                 = busy_q;
  assign result_valid_o       = rvalid_q;
  assign status_o             = status_q;
  assign release_underlying_o = release_q;
  assign ref_count_o          = refs_q;

endmodule : open_handle_lock_table_unit
`default_nettype wire

// ===== rtl/ohlt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ohlt_checker
// Port-level checks on the open-handle lock table, bound to the top level.
// ----------------------------------------------------------------------------
module ohlt_checker
  import ohlt_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       opcode_i,
  input wire logic [KEY_W-1:0] handle_key_i,
  input wire logic [KEY_W-1:0] file_key_i,
  input wire logic             want_exclusive_i,
  input wire logic             result_valid_o,
  input wire logic [2:0]       status_o,
  input wire logic             release_underlying_o,
  input wire logic [REF_W-1:0] ref_count_o
);

  // every result follows a command in flight or one just taken
  a_result_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) || $past(start)))
    else $error("result without a pending command");

  // the end of a busy period always delivers its result
  a_busy_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  // a release is a successful close that leaves no reference
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && release_underlying_o) |->
      ((status_o == ST_OK) && (ref_count_o == '0)))
    else $error("release with bad status or refcount");

  // failed commands report no refcount, overflow reports the maximum
  a_fail_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |->
      (!release_underlying_o &&
       (((status_o == ST_OVERFLOW) && (ref_count_o == REF_MAX)) ||
        ((status_o != ST_OVERFLOW) && (ref_count_o == '0)))))
    else $error("failed command with wrong refcount");

endmodule : ohlt_checker

bind open_handle_lock_table_unit ohlt_checker u_ohlt_checker (.*);
`default_nettype wire
